[rtl/sm4cbc_pkg.sv]
// shared constants and round functions for the sm4 cbc cipher
package sm4cbc_pkg;

  localparam int RoundCount = 32;
  localparam int RndW       = $clog2(RoundCount);
  localparam int BlkW       = 128;
  localparam int HalfW      = 64;
  localparam int WordW      = 32;
  localparam int CfgIdxW    = 3;

  localparam logic [CfgIdxW-1:0] CFG_KEY_HIGH     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_KEY_LOW      = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_IV_HIGH      = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_IV_LOW       = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DECRYPT_MODE = 3'd4;

  localparam logic [WordW-1:0] FK0 = 32'ha3b1bac6;
  localparam logic [WordW-1:0] FK1 = 32'h56aa3350;
  localparam logic [WordW-1:0] FK2 = 32'h677d9197;
  localparam logic [WordW-1:0] FK3 = 32'hb27022dc;

  localparam logic [7:0] SBOX [256] = '{
    8'hD6, 8'h90, 8'hE9, 8'hFE, 8'hCC, 8'hE1, 8'h3D, 8'hB7, 8'h16, 8'hB6, 8'h14, 8'hC2,
    8'h28, 8'hFB, 8'h2C, 8'h05, 8'h2B, 8'h67, 8'h9A, 8'h76, 8'h2A, 8'hBE, 8'h04, 8'hC3,
    8'hAA, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99, 8'h9C, 8'h42, 8'h50, 8'hF4,
    8'h91, 8'hEF, 8'h98, 8'h7A, 8'h33, 8'h54, 8'h0B, 8'h43, 8'hED, 8'hCF, 8'hAC, 8'h62,
    8'hE4, 8'hB3, 8'h1C, 8'hA9, 8'hC9, 8'h08, 8'hE8, 8'h95, 8'h80, 8'hDF, 8'h94, 8'hFA,
    8'h75, 8'h8F, 8'h3F, 8'hA6, 8'h47, 8'h07, 8'hA7, 8'hFC, 8'hF3, 8'h73, 8'h17, 8'hBA,
    8'h83, 8'h59, 8'h3C, 8'h19, 8'hE6, 8'h85, 8'h4F, 8'hA8, 8'h68, 8'h6B, 8'h81, 8'hB2,
    8'h71, 8'h64, 8'hDA, 8'h8B, 8'hF8, 8'hEB, 8'h0F, 8'h4B, 8'h70, 8'h56, 8'h9D, 8'h35,
    8'h1E, 8'h24, 8'h0E, 8'h5E, 8'h63, 8'h58, 8'hD1, 8'hA2, 8'h25, 8'h22, 8'h7C, 8'h3B,
    8'h01, 8'h21, 8'h78, 8'h87, 8'hD4, 8'h00, 8'h46, 8'h57, 8'h9F, 8'hD3, 8'h27, 8'h52,
    8'h4C, 8'h36, 8'h02, 8'hE7, 8'hA0, 8'hC4, 8'hC8, 8'h9E, 8'hEA, 8'hBF, 8'h8A, 8'hD2,
    8'h40, 8'hC7, 8'h38, 8'hB5, 8'hA3, 8'hF7, 8'hF2, 8'hCE, 8'hF9, 8'h61, 8'h15, 8'hA1,
    8'hE0, 8'hAE, 8'h5D, 8'hA4, 8'h9B, 8'h34, 8'h1A, 8'h55, 8'hAD, 8'h93, 8'h32, 8'h30,
    8'hF5, 8'h8C, 8'hB1, 8'hE3, 8'h1D, 8'hF6, 8'hE2, 8'h2E, 8'h82, 8'h66, 8'hCA, 8'h60,
    8'hC0, 8'h29, 8'h23, 8'hAB, 8'h0D, 8'h53, 8'h4E, 8'h6F, 8'hD5, 8'hDB, 8'h37, 8'h45,
    8'hDE, 8'hFD, 8'h8E, 8'h2F, 8'h03, 8'hFF, 8'h6A, 8'h72, 8'h6D, 8'h6C, 8'h5B, 8'h51,
    8'h8D, 8'h1B, 8'hAF, 8'h92, 8'hBB, 8'hDD, 8'hBC, 8'h7F, 8'h11, 8'hD9, 8'h5C, 8'h41,
    8'h1F, 8'h10, 8'h5A, 8'hD8, 8'h0A, 8'hC1, 8'h31, 8'h88, 8'hA5, 8'hCD, 8'h7B, 8'hBD,
    8'h2D, 8'h74, 8'hD0, 8'h12, 8'hB8, 8'hE5, 8'hB4, 8'hB0, 8'h89, 8'h69, 8'h97, 8'h4A,
    8'h0C, 8'h96, 8'h77, 8'h7E, 8'h65, 8'hB9, 8'hF1, 8'h09, 8'hC5, 8'h6E, 8'hC6, 8'h84,
    8'h18, 8'hF0, 8'h7D, 8'hEC, 8'h3A, 8'hDC, 8'h4D, 8'h20, 8'h79, 8'hEE, 8'h5F, 8'h3E,
    8'hD7, 8'hCB, 8'h39, 8'h48
  };

  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] b, input int n);
    return (b << n) | (b >> (WordW - n));
  endfunction

  function automatic logic [WordW-1:0] tau(input logic [WordW-1:0] x);
    return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
  endfunction

  // byte j of ck word i is (4*i + j) * 7 mod 256, byte 0 on top
  function automatic logic [WordW-1:0] ck_word(input logic [RndW-1:0] i);
    logic [WordW-1:0] w;
    logic [7:0]       b;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      b = 8'({1'b0, i, 2'(j)} * 8'd7);
      w = {w[23:0], b};
    end
    return w;
  endfunction

endpackage

[rtl/sm4_cbc_block_cipher.sv]
// sm4 cbc block cipher with a shared round unit for key schedule and data rounds
//
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: block_high, block_low; tuser: first_block
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: out_high, out_low
// cfg       in   cfg_we_i                     cfg_idx_i, cfg_data_i
//
// each block runs accept, then 32 rounds of the shared t unit, then the finish step
// after reset and after each key write the key schedule loads the key and runs 32 rounds, s_axis_tready low
// the finish cycle waits while the previous result word is still held on m_axis
// reset clears key, iv, mode and chain value to zero
module sm4_cbc_block_cipher
  import sm4cbc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [HalfW-1:0]    cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [BlkW-1:0]     s_axis_tdata,   // block_high, block_low
  input  logic                s_axis_tuser,   // first_block
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [BlkW-1:0]     m_axis_tdata    // out_high, out_low
);

  localparam logic [2:0] ST_KLOAD = 3'd0;
  localparam logic [2:0] ST_KEXP  = 3'd1;
  localparam logic [2:0] ST_IDLE  = 3'd2;
  localparam logic [2:0] ST_RUN   = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [RndW-1:0]  cnt_q, cnt_d;
  logic [HalfW-1:0] key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
  logic             dec_q, dir_q;
  logic [BlkW-1:0]  chain_q, xor_q, res_q;
  logic             m_valid_q;
  logic [WordW-1:0] w_q [4];
  logic [WordW-1:0] rk_q [RoundCount];

  logic             key_wr, accept, fin_go;
  logic [BlkW-1:0]  in_blk, chain_src, fin_blk;
  logic [WordW-1:0] rk_sel, t_in, t_sb, t_lin, new_word;
  logic [RndW-1:0]  rk_idx;

  assign key_wr = cfg_we_i && (cfg_idx_i == CFG_KEY_HIGH || cfg_idx_i == CFG_KEY_LOW);
  assign s_axis_tready = (state_q == ST_IDLE) && !key_wr;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign in_blk = {s_axis_tdata[HalfW-1:0], s_axis_tdata[BlkW-1:HalfW]};
  assign chain_src = s_axis_tuser ? {iv_hi_q, iv_lo_q} : chain_q;
  assign fin_blk = {w_q[3], w_q[2], w_q[1], w_q[0]} ^ xor_q;
  assign fin_go = (state_q == ST_FIN) && (!m_valid_q || m_axis_tready);

  // shared round unit
  assign rk_idx = dir_q ? ~cnt_q : cnt_q;
  assign rk_sel = (state_q == ST_KEXP) ? ck_word(cnt_q) : rk_q[rk_idx];
  assign t_in   = w_q[1] ^ w_q[2] ^ w_q[3] ^ rk_sel;
  assign t_sb   = tau(t_in);
  always_comb begin
    if (state_q == ST_KEXP) begin
      t_lin = t_sb ^ rotl(t_sb, 13) ^ rotl(t_sb, 23);
    end else begin
      t_lin = t_sb ^ rotl(t_sb, 2) ^ rotl(t_sb, 10) ^ rotl(t_sb, 18) ^ rotl(t_sb, 24);
    end
  end
  assign new_word = w_q[0] ^ t_lin;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    if (key_wr) begin
      state_d = ST_KLOAD;
    end else begin
      unique case (state_q)
        ST_KLOAD: begin
          state_d = ST_KEXP;
          cnt_d   = '0;
        end
        ST_KEXP: begin
          cnt_d = cnt_q + 1'b1;
          if (&cnt_q) state_d = ST_IDLE;
        end
        ST_IDLE: begin
          if (accept) begin
            state_d = ST_RUN;
            cnt_d   = '0;
          end
        end
        ST_RUN: begin
          cnt_d = cnt_q + 1'b1;
          if (&cnt_q) state_d = ST_FIN;
        end
        ST_FIN: begin
          if (fin_go) state_d = ST_IDLE;
        end
        default: state_d = ST_KLOAD;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_KLOAD;
      cnt_q     <= '0;
      key_hi_q  <= '0;
      key_lo_q  <= '0;
      iv_hi_q   <= '0;
      iv_lo_q   <= '0;
      dec_q     <= 1'b0;
      chain_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_KEY_HIGH:     key_hi_q <= cfg_data_i;
          CFG_KEY_LOW:      key_lo_q <= cfg_data_i;
          CFG_IV_HIGH:      iv_hi_q  <= cfg_data_i;
          CFG_IV_LOW:       iv_lo_q  <= cfg_data_i;
          CFG_DECRYPT_MODE: dec_q    <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (accept && dec_q) begin
        chain_q <= in_blk;
      end else if (fin_go && !dir_q) begin
        chain_q <= fin_blk;
      end
      if (fin_go) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_go) res_q <= fin_blk;
    if (state_q == ST_KEXP && !key_wr) rk_q[cnt_q] <= new_word;
    if (key_wr) begin
      w_q <= w_q;
    end else if (state_q == ST_KLOAD) begin
      w_q[0] <= key_hi_q[63:32] ^ FK0;
      w_q[1] <= key_hi_q[31:0]  ^ FK1;
      w_q[2] <= key_lo_q[63:32] ^ FK2;
      w_q[3] <= key_lo_q[31:0]  ^ FK3;
    end else if (accept) begin
      dir_q <= dec_q;
      if (dec_q) begin
        {w_q[0], w_q[1], w_q[2], w_q[3]} <= in_blk;
        xor_q <= chain_src;
      end else begin
        {w_q[0], w_q[1], w_q[2], w_q[3]} <= in_blk ^ chain_src;
        xor_q <= '0;
      end
    end else if (state_q == ST_KEXP || state_q == ST_RUN) begin
      w_q[0] <= w_q[1];
      w_q[1] <= w_q[2];
      w_q[2] <= w_q[3];
      w_q[3] <= new_word;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {res_q[HalfW-1:0], res_q[BlkW-1:HalfW]};

  a_accept_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_RUN && cnt_q == '0)
    else $error("accepted word did not start the rounds");

  a_key_write_reloads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_wr |=> state_q == ST_KLOAD)
    else $error("key write did not restart the key schedule");

  a_valid_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q) == ST_FIN)
    else $error("result shown without a finished block");

  a_run_ends_in_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN && (&cnt_q) && !key_wr |=> state_q == ST_FIN)
    else $error("last round did not lead to finish");

endmodule
